// ===== hdl/tmaf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmaf_pkg
// Shared widths, defaults and types for the trimmed moving average filter.
// ----------------------------------------------------------------------------
package tmaf_pkg;

  localparam int RAW_W        = 10;
  localparam int SAMPLE_SHIFT = 3;
  localparam int SAMPLE_W     = RAW_W - SAMPLE_SHIFT;
  localparam int OUT_W        = 7;
  localparam int WINDOW_DEF   = 100;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/tmaf_stream_if.sv =====
// ----------------------------------------------------------------------------
// tmaf stream interfaces
// Valid/ready channels for converter samples and filtered results.
// ----------------------------------------------------------------------------
interface tmaf_in_if;
  logic                       valid;
  logic                       ready;
  logic [tmaf_pkg::RAW_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface tmaf_out_if;
  logic                       valid;
  logic                       ready;
  logic [tmaf_pkg::OUT_W-1:0] filtered_value;

  modport source (output valid, output filtered_value, input ready);
  modport sink   (input valid, input filtered_value, output ready);
endinterface

// ===== hdl/tmaf_cell.sv =====
// ----------------------------------------------------------------------------
// tmaf_cell
// One window entry: loads its neighbor's sample when the chain moves.
// ----------------------------------------------------------------------------
module tmaf_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [tmaf_pkg::SAMPLE_W-1:0] d_in,
  output logic [tmaf_pkg::SAMPLE_W-1:0] d_out
);
  import tmaf_pkg::*;

  logic [SAMPLE_W-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (en) begin
      sample_r <= d_in;
    end
  end

  assign d_out = sample_r;

endmodule

// ===== hdl/tmaf_divider.sv =====
// ----------------------------------------------------------------------------
// tmaf_divider
// Division by the constant WINDOW-1 through a reciprocal multiply: the
// dividend is registered first, the quotient in the cycle after.
// ----------------------------------------------------------------------------
module tmaf_divider #(
  parameter int WINDOW = tmaf_pkg::WINDOW_DEF,
  parameter int SUM_W  = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SUM_W-1:0]           dividend,
  output logic [tmaf_pkg::OUT_W-1:0] quotient,
  output tmaf_pkg::div_stat_t        stat
);
  import tmaf_pkg::*;

  // multiplier rounded up; exact for every dividend below 2**SUM_W
  localparam int                 DIVISOR = WINDOW - 1;
  localparam int                 SHIFT   = SUM_W + $clog2(DIVISOR);
  localparam longint unsigned    RECIP   = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int                 RECIP_W = $clog2(RECIP + 1);
  localparam int                 PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [SUM_W-1:0]  dvd_r;
  logic [OUT_W-1:0]  q_r;
  logic              busy_r;
  logic              done_r;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(dvd_r) * PROD_W'(RECIP_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r    <= prod[SHIFT +: OUT_W];
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without multiply");

endmodule

// ===== hdl/trimmed_moving_average_filter_top.sv =====
// Each accepted sample beat starts one circulation of the window through the
//   cell chain and then the two-stage divider; no new sample is taken until
//   the block is back in idle after loading the result into the output register.
// The input is taken again while a result still waits in the output register.
// Reset (synchronous, active low) zeroes every window entry and empties the
//   output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// trimmed_moving_average_filter_top
// Shift window of reduced samples with min/max trimming and averaging.
// ----------------------------------------------------------------------------
module trimmed_moving_average_filter_top #(
  parameter int WINDOW = tmaf_pkg::WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tmaf_in_if.sink    in_chan,
  tmaf_out_if.source out_chan
);
  import tmaf_pkg::*;

  localparam int SUM_W = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int CNT_W = $clog2(WINDOW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] min_r;
  logic [SAMPLE_W-1:0] max_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_value_r;

  logic [SAMPLE_W-1:0] cell_q [WINDOW];
  logic [SAMPLE_W-1:0] head;
  logic [SAMPLE_W-1:0] reduced;
  logic                accept;
  logic                scan;
  logic                chain_en;
  logic                scan_last;
  logic                out_free;
  logic                load_out;
  logic [SUM_W:0]      trimmed;
  logic [SUM_W-1:0]    dividend;
  logic [OUT_W-1:0]    quotient;
  div_stat_t           div_stat;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign scan          = (state_r == ST_SCAN);
  assign chain_en      = accept || scan;
  assign scan_last     = scan && (cnt_r == CNT_LAST);
  assign reduced       = in_chan.raw_sample[RAW_W-1:SAMPLE_SHIFT];
  assign head          = cell_q[0];
  assign out_free      = !out_valid_r || out_chan.ready;
  assign load_out      = out_free && ((state_r == ST_DIV && div_stat.done) ||
                                      state_r == ST_HOLD);

  // entry 0 is the oldest; on a sample beat the chain shifts toward it,
  // during the scan the window circulates once back to its own order
  genvar k;
  generate
    for (k = 0; k < WINDOW; k++) begin : g_cell
      logic [SAMPLE_W-1:0] d_in;
      if (k == WINDOW - 1) begin : g_tail
        assign d_in = scan ? cell_q[0] : reduced;
      end else begin : g_body
        assign d_in = cell_q[k+1];
      end
      tmaf_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (chain_en),
        .d_in  (d_in),
        .d_out (cell_q[k])
      );
    end
  endgenerate

  // sum of all entries less the extremes of the older ones
  assign trimmed  = (SUM_W+1)'(sum_r) + (SUM_W+1)'(head)
                  - (SUM_W+1)'(min_r) - (SUM_W+1)'(max_r);
  assign dividend = trimmed[SUM_W-1:0];

  tmaf_divider #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_last),
    .dividend (dividend),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_value_r <= quotient;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cnt_r   <= '0;
            sum_r   <= '0;
            min_r   <= SAMPLE_W'(SAMPLE_MAX);
            max_r   <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          sum_r <= sum_r + SUM_W'(head);
          // the newest entry is the last one to pass the head
          if (cnt_r != CNT_LAST) begin
            if (head < min_r) begin
              min_r <= head;
            end
            if (head > max_r) begin
              max_r <= head;
            end
            cnt_r <= cnt_r + CNT_W'(1);
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (out_free) begin
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.filtered_value = out_value_r;

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SCAN && cnt_r == '0)
    else $error("sample beat did not start a scan");

  a_scan_div: assert property (@(posedge clk) disable iff (!rst_n)
    scan_last |=> state_r == ST_DIV && div_stat.busy)
    else $error("scan end did not start the divider");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider result outside division state");

  a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && cnt_r != '0) |-> min_r <= max_r)
    else $error("window extremes out of order");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams converter samples into the trimmed moving average filter under
// random burst gaps and output stalls, tracks the sample window alongside
// the block and checks every filtered value in order.
// ----------------------------------------------------------------------------
module testbench;
  import tmaf_pkg::*;

  localparam int WIN          = WINDOW_DEF;
  localparam int NUM_RANDOM   = 430;
  localparam int IDLE_LIMIT   = 5000;
  localparam int LONG_HOLD    = 700;
  localparam int HOLD_AT      = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [RAW_W-1:0] raw;
    bit               drain_first;
  } sample_req_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  typedef enum logic [1:0] {
    SEG_LEVEL,
    SEG_NOISE,
    SEG_RAIL
  } segment_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  tmaf_in_if  in_if ();
  tmaf_out_if out_if ();

  trimmed_moving_average_filter_top #(
    .WINDOW(WIN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_req_t          sample_queue[$];
  logic [OUT_W-1:0]     avg_expect_q[$];
  logic [SAMPLE_W-1:0]  sample_hist[WIN];

  int unsigned fail_cnt;
  int unsigned samples_queued;
  int unsigned samples_taken;
  int unsigned results_seen;
  int unsigned idle_cycles;

  // trimmed average of the window after shifting in one sample
  function automatic logic [OUT_W-1:0] trimmed_avg_step(input logic [RAW_W-1:0] raw);
    int unsigned total;
    int unsigned lo;
    int unsigned hi;
    int unsigned v;
    total = 0;
    lo    = 255;
    hi    = 0;
    for (int k = 1; k < WIN; k++) begin
      sample_hist[k-1] = sample_hist[k];
      v = sample_hist[k-1];
      total += v;
      if (v < lo) lo = v;
      if (v > hi) hi = v;
    end
    // newest entry joins the sum but not the min/max search
    sample_hist[WIN-1] = raw[RAW_W-1:SAMPLE_SHIFT];
    total += sample_hist[WIN-1];
    total = total - lo - hi;
    return OUT_W'(total / (WIN - 1));
  endfunction

  task automatic add_sample(input logic [RAW_W-1:0] raw, input bit drain_first);
    sample_req_t req;
    req.raw         = raw;
    req.drain_first = drain_first;
    sample_queue.push_back(req);
    samples_queued++;
  endtask

  function automatic void note_failure(input string msg);
    if (fail_cnt < MAX_REPORTS) $display("%s", msg);
    fail_cnt++;
  endfunction

  // sender: bursts of random length separated by random gaps
  int unsigned gap_left;
  int unsigned burst_left;
  logic        next_valid;
  sample_req_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.raw_sample <= '0;
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        avg_expect_q.push_back(trimmed_avg_step(in_if.raw_sample));
        samples_taken++;
      end
      if (in_if.valid && !in_if.ready) begin
        next_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        next_valid = 1'b0;
      end else if (sample_queue.size() == 0) begin
        next_valid = 1'b0;
      end else if (sample_queue[0].drain_first && avg_expect_q.size() != 0) begin
        next_valid = 1'b0;
      end else begin
        next_valid = 1'b1;
        next_req   = sample_queue.pop_front();
        in_if.raw_sample <= next_req.raw;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
        end else begin
          burst_left--;
        end
      end
      in_if.valid <= next_valid;
    end
  end

  // receiver: changing stall patterns plus one long hold-off
  stall_mode_t stall_mode;
  int unsigned mode_left;
  int unsigned hold_left;
  int unsigned stall_phase;
  bit          long_hold_done;
  logic        next_ready;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_mode     = STALL_NONE;
      mode_left      = 0;
      hold_left      = 0;
      stall_phase    = 0;
      long_hold_done = 1'b0;
    end else begin
      stall_phase++;
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AT) begin
        // sender keeps going, so the block backs up and stalls its input
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        next_ready     = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(50, 800);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:     next_ready = 1'b1;
          STALL_COIN:     next_ready = $urandom_range(0, 1);
          STALL_PERIODIC: next_ready = (stall_phase % 4) != 0;
          default:        next_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
      out_if.ready <= next_ready;
    end
  end

  // result checker
  logic [OUT_W-1:0] want;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (avg_expect_q.size() == 0) begin
        note_failure($sformatf("unexpected result beat: filtered_value %0d",
                               out_if.filtered_value));
      end else begin
        want = avg_expect_q.pop_front();
        if (out_if.filtered_value !== want)
          note_failure($sformatf("mismatch on result %0d: filtered_value expected %0d got %0d",
                                 results_seen, want, out_if.filtered_value));
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    segment_kind_t    kind;
    int unsigned      seg_len;
    int               base;
    int               val;
    bit               drain;
    logic [RAW_W-1:0] directed_raw[];

    directed_raw = '{
      0, 0, 1023, 1023, 7, 8, 1016, 1015, 1023, 0,
      512, 511, 256, 128, 64, 32, 16, 1, 2, 4,
      1023, 1023, 0
    };
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.raw_sample = '0;
    out_if.ready     = 1'b0;
    fail_cnt         = 0;
    samples_queued   = 0;
    samples_taken    = 0;
    results_seen     = 0;
    idle_cycles      = 0;
    for (int k = 0; k < WIN; k++) sample_hist[k] = '0;

    // start-up ramp from the zeroed window, field extremes, low bits dropped
    foreach (directed_raw[i]) add_sample(directed_raw[i], 1'b0);

    // first random segment pins the window near full scale, after a drain
    for (int i = 0; i < WIN + 10; i++)
      add_sample(RAW_W'($urandom_range(1016, 1023)), i == 0);

    while (samples_queued < directed_raw.size() + NUM_RANDOM) begin
      kind    = segment_kind_t'($urandom_range(0, 2));
      drain   = ($urandom_range(0, 5) == 0);
      case (kind)
        SEG_LEVEL: begin
          // slow slider: a steady level with small jitter
          seg_len = $urandom_range(20, 150);
          base    = $urandom_range(0, 1023);
          for (int i = 0; i < seg_len; i++) begin
            val = base + $urandom_range(0, 32) - 16;
            if (val < 0) val = 0;
            if (val > 1023) val = 1023;
            add_sample(RAW_W'(val), drain && i == 0);
          end
        end
        SEG_NOISE: begin
          seg_len = $urandom_range(5, 30);
          for (int i = 0; i < seg_len; i++)
            add_sample(RAW_W'($urandom_range(0, 1023)), drain && i == 0);
        end
        default: begin
          seg_len = $urandom_range(10, 120);
          base    = $urandom_range(0, 1);
          for (int i = 0; i < seg_len; i++)
            add_sample(base ? RAW_W'($urandom_range(1016, 1023))
                            : RAW_W'($urandom_range(0, 7)), drain && i == 0);
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (samples_taken < samples_queued || avg_expect_q.size() != 0)
      @(posedge clk);
    repeat (WIN + 20) @(posedge clk);

    if (avg_expect_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", avg_expect_q.size()));

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
